>>> src/lse_pkg.sv
// Shared types and constants for the LED strip effect engine.
// No dependencies; used by lse_ctrl, lse_datapath and the top level.
`default_nettype none

package lse_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RAINBOW_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANIMATE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX     = 3'd6;

  // Color source codes (code 3 behaves as hold)
  localparam logic [1:0] MODE_FIXED   = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_HOLD    = 2'd2;

  // Hue sector width of the integer HSV conversion
  localparam int HUE_SECTOR = 43;

  // pi in Q28, base of the wave table
  localparam logic [63:0] PI_Q28 = 64'd843314857;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HUE,
    ST_COLOR,
    ST_PIXELS
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // latch input beat
    logic step;     // advance hue and brightness
    logic load;     // settle frame color
    logic issue;    // launch one pixel into the pipeline
  } lse_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic adv;      // pixel pipeline may move
    logic at_last;  // pixel counter on the final LED
  } lse_status_t;

endpackage

`default_nettype wire

>>> src/lse_ctrl.sv
// Frame sequencer for the LED strip effect engine.
// Depends on lse_pkg (state enum, command and status structs).
`default_nettype none

module lse_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lse_pkg::lse_status_t status,
  output lse_pkg::lse_cmd_t    cmd
);

  lse_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lse_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = lse_pkg::ST_HUE;
        end
      end
      lse_pkg::ST_HUE: begin
        cmd.step   = 1'b1;
        state_next = lse_pkg::ST_COLOR;
      end
      lse_pkg::ST_COLOR: begin
        cmd.load   = 1'b1;
        state_next = lse_pkg::ST_PIXELS;
      end
      lse_pkg::ST_PIXELS: begin
        if (status.adv) begin
          cmd.issue = 1'b1;
          if (status.at_last) begin
            state_next = lse_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/lse_datapath.sv
// Datapath: config registers, hue/brightness/color state, wave table and
// the two-stage pixel scaling pipeline. Depends on lse_pkg.
`default_nettype none

module lse_datapath #(
  parameter int NUM_LEDS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [lse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [lse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_phone_up,
  input  lse_pkg::lse_cmd_t                cmd,
  output lse_pkg::lse_status_t             status,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic [5:0]                       out_index,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_last
);

  localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // ---------------- wave table, built at elaboration ----------------
  logic [8:0] wave_rom [NUM_LEDS];

  for (genvar t = 0; t < NUM_LEDS; t++) begin : g_wave
    localparam bit          ACTIVE = (t != 0) && (2 * t < NUM_LEDS);
    localparam logic [63:0] TWO_T  = 64'(2 * t);
    localparam logic [63:0] REST   = 64'(NUM_LEDS) - TWO_T;
    localparam logic [63:0] U      = !ACTIVE ? 64'd0 : ((REST < TWO_T) ? REST : TWO_T);
    localparam logic [63:0] X      = (lse_pkg::PI_Q28 * U) / 64'(NUM_LEDS);
    localparam logic [63:0] X2     = (X * X) >> 28;
    localparam logic [63:0] T1     = (X * X2) / 64'd6;
    localparam logic [63:0] A1     = (X >= T1) ? X - T1 : 64'd0;
    localparam logic [63:0] T2     = (T1 * X2) / 64'd20;
    localparam logic [63:0] A2     = A1 + T2;
    localparam logic [63:0] T3     = (T2 * X2) / 64'd42;
    localparam logic [63:0] A3     = (A2 >= T3) ? A2 - T3 : 64'd0;
    localparam logic [63:0] T4     = (T3 * X2) / 64'd72;
    localparam logic [63:0] A4     = A3 + T4;
    localparam logic [63:0] T5     = (T4 * X2) / 64'd110;
    localparam logic [63:0] A5     = (A4 >= T5) ? A4 - T5 : 64'd0;
    localparam logic [63:0] W      = (A5 + (64'd1 << 19)) >> 20;
    localparam logic [63:0] WC     = (W > 64'd256) ? 64'd256 : W;
    localparam logic [8:0]  ENTRY  = ACTIVE ? WC[8:0] : 9'd0;
    assign wave_rom[t] = ENTRY;
  end

  // floor(p / 255) for p <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    begin
      s = 17'(p) + 17'(p >> 8) + 17'd1;
      div255 = s[15:8];
    end
  endfunction

  // ---------------- configuration registers ----------------
  logic [1:0] rainbow_mode;
  logic       animate_enable;
  logic [7:0] base_red, base_green, base_blue;
  logic [7:0] bright_min, bright_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      rainbow_mode   <= lse_pkg::MODE_FIXED;
      animate_enable <= 1'b0;
      base_red       <= 8'd255;
      base_green     <= 8'd255;
      base_blue      <= 8'd255;
      bright_min     <= 8'd16;
      bright_max     <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        lse_pkg::REG_RAINBOW_MODE:   rainbow_mode   <= cfg_data[1:0];
        lse_pkg::REG_ANIMATE_ENABLE: animate_enable <= cfg_data[0];
        lse_pkg::REG_BASE_RED:       base_red       <= cfg_data;
        lse_pkg::REG_BASE_GREEN:     base_green     <= cfg_data;
        lse_pkg::REG_BASE_BLUE:      base_blue      <= cfg_data;
        lse_pkg::REG_BRIGHT_MIN:     bright_min     <= cfg_data;
        lse_pkg::REG_BRIGHT_MAX:     bright_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- frame state ----------------
  logic          phone_up_q, wave_tick;
  logic [7:0]    hue, brightness;
  logic [7:0]    fc_r, fc_g, fc_b;
  logic [IW-1:0] wave_offset, count;

  // HSV to RGB at saturation 255, value bright_max
  logic [2:0]  region;
  logic [7:0]  sector_base, rem;
  logic [15:0] rem_x255, inv_x255;
  logic [7:0]  fall, rise;
  logic [15:0] q_prod, t_prod;
  logic [7:0]  hq, ht, v;
  logic [7:0]  hsv_r, hsv_g, hsv_b;
  logic [7:0]  target;

  always_comb begin
    v = bright_max;
    if (hue < 8'(lse_pkg::HUE_SECTOR)) begin
      region = 3'd0;
    end else if (hue < 8'(2 * lse_pkg::HUE_SECTOR)) begin
      region = 3'd1;
    end else if (hue < 8'(3 * lse_pkg::HUE_SECTOR)) begin
      region = 3'd2;
    end else if (hue < 8'(4 * lse_pkg::HUE_SECTOR)) begin
      region = 3'd3;
    end else if (hue < 8'(5 * lse_pkg::HUE_SECTOR)) begin
      region = 3'd4;
    end else begin
      region = 3'd5;
    end
    sector_base = 8'(region) * 8'(lse_pkg::HUE_SECTOR);
    rem         = 8'((hue - sector_base) * 8'd6);
    rem_x255    = {rem, 8'd0} - 16'(rem);
    inv_x255    = {8'd255 - rem, 8'd0} - 16'(8'd255 - rem);
    fall        = 8'd255 - rem_x255[15:8];
    rise        = 8'd255 - inv_x255[15:8];
    q_prod      = 16'(v) * 16'(fall);
    t_prod      = 16'(v) * 16'(rise);
    hq          = q_prod[15:8];
    ht          = t_prod[15:8];
    case (region)
      3'd0:    begin hsv_r = v;    hsv_g = ht;   hsv_b = 8'd0; end
      3'd1:    begin hsv_r = hq;   hsv_g = v;    hsv_b = 8'd0; end
      3'd2:    begin hsv_r = 8'd0; hsv_g = v;    hsv_b = ht;   end
      3'd3:    begin hsv_r = 8'd0; hsv_g = hq;   hsv_b = v;    end
      3'd4:    begin hsv_r = ht;   hsv_g = 8'd0; hsv_b = v;    end
      default: begin hsv_r = v;    hsv_g = 8'd0; hsv_b = hq;   end
    endcase
    target = phone_up_q ? bright_min : bright_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phone_up_q  <= 1'b0;
      wave_tick   <= 1'b0;
      hue         <= 8'd0;
      brightness  <= 8'd0;
      fc_r        <= 8'd255;
      fc_g        <= 8'd255;
      fc_b        <= 8'd255;
      wave_offset <= '0;
    end else begin
      if (cmd.accept) begin
        phone_up_q <= in_phone_up;
        wave_tick  <= in_phone_up & animate_enable;
      end
      if (cmd.step) begin
        if (rainbow_mode == lse_pkg::MODE_RAINBOW) begin
          hue <= hue + 8'd1;
        end
        if (!wave_tick) begin
          if (brightness < target) begin
            brightness <= brightness + 8'd1;
          end else if (brightness > target) begin
            brightness <= brightness - 8'd1;
          end
        end
      end
      if (cmd.load) begin
        if (rainbow_mode == lse_pkg::MODE_RAINBOW) begin
          fc_r <= hsv_r;
          fc_g <= hsv_g;
          fc_b <= hsv_b;
        end else if (rainbow_mode == lse_pkg::MODE_FIXED) begin
          fc_r <= base_red;
          fc_g <= base_green;
          fc_b <= base_blue;
        end
      end
      if (cmd.issue && status.at_last && wave_tick) begin
        wave_offset <= (wave_offset == IW'(NUM_LEDS - 1)) ? '0 : wave_offset + IW'(1);
      end
    end
  end

  // ---------------- pixel pipeline ----------------
  logic [IW:0]   wsum;
  logic [IW-1:0] widx;
  logic [8:0]    scale;

  always_comb begin
    wsum = {1'b0, count} + {1'b0, wave_offset};
    widx = (wsum >= (IW+1)'(NUM_LEDS)) ? IW'(wsum - (IW+1)'(NUM_LEDS)) : wsum[IW-1:0];
    scale = wave_tick ? wave_rom[widx] : {1'b0, brightness};
  end

  assign status.adv     = !out_valid || out_ready;
  assign status.at_last = (count == IW'(NUM_LEDS - 1));

  logic          s1_valid, s1_last, s1_wave;
  logic [IW-1:0] s1_idx;
  logic [16:0]   s1_pr, s1_pg, s1_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (status.adv) begin
      s1_valid  <= cmd.issue;
      out_valid <= s1_valid;
      if (cmd.issue) begin
        count <= status.at_last ? '0 : count + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.adv) begin
      if (cmd.issue) begin
        s1_idx  <= count;
        s1_last <= status.at_last;
        s1_wave <= wave_tick;
        s1_pr   <= 17'(fc_r) * 17'(scale);
        s1_pg   <= 17'(fc_g) * 17'(scale);
        s1_pb   <= 17'(fc_b) * 17'(scale);
      end
      out_index <= 6'(s1_idx);
      out_last  <= s1_last;
      out_red   <= s1_wave ? s1_pr[15:8] : div255(s1_pr[15:0]);
      out_green <= s1_wave ? s1_pg[15:8] : div255(s1_pg[15:0]);
      out_blue  <= s1_wave ? s1_pb[15:8] : div255(s1_pb[15:0]);
    end
  end

endmodule

`default_nettype wire

>>> src/led_strip_effect_engine.sv
// LED strip effect engine, top level: frame sequencer plus datapath.
// Depends on lse_pkg, lse_ctrl and lse_datapath.
//
// Usage:
//   s_axis carries one beat per frame tick; tdata[0] is phone_up.
//   For each tick the block emits NUM_LEDS beats on m_axis, pixel 0 first,
//   with tlast on the final LED. The cfg port writes one register per cycle
//   (index per the register list) and is meant to be used only while idle.
// Timing:
//   After a tick is taken, the ST_HUE state steps hue and brightness, the
//   ST_COLOR state settles the frame color (HSV converter in rainbow mode),
//   then one pixel is launched per cycle, unless the output stalls, into a
//   two-stage scale pipeline (multiply, then divide-by-255 or wave shift).
//   The next tick can be taken the cycle after the last pixel launches,
//   while the final results are still draining.
// Reset: synchronous; state other than pixel data returns to power-on values,
//   no output beat is pending and s_axis_tready is high once the sequencer is idle.
// Stall: m_axis_tready low with a beat pending freezes the pixel pipeline,
//   the pixel counter and pixel launch; nothing is dropped.
`default_nettype none

module led_strip_effect_engine #(
  parameter int NUM_LEDS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  // config write port
  input  wire                             cfg_we,
  input  wire  [lse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [lse_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input beats
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [7:0]                      s_axis_tdata,  // [0] phone_up, [7:1] zero
  // output beats
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // [5:0] pixel_index, [13:6] red,
                                                         // [21:14] green, [29:22] blue,
                                                         // [31:30] zero
  output logic                            m_axis_tlast   // last_pixel
);

  lse_pkg::lse_cmd_t    cmd;
  lse_pkg::lse_status_t status;

  logic [5:0] px_index;
  logic [7:0] px_red, px_green, px_blue;

  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lse_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_phone_up (s_axis_tdata[0]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_index   (px_index),
    .out_red     (px_red),
    .out_green   (px_green),
    .out_blue    (px_blue),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, px_blue, px_green, px_red, px_index};

  // A taken tick keeps the input closed while its frame is prepared.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after accepting a tick");

  // tlast marks exactly the final LED.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:0] == 6'(NUM_LEDS - 1))))
    else $error("tlast and pixel index disagree");

  // Pixel indices stay inside the strip.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[5:0]) < 32'(NUM_LEDS)))
    else $error("pixel index beyond strip length");

  // Pixels are only launched while the pipeline can move.
  a_issue_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.adv)
    else $error("pixel launched into a stalled pipeline");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for led_strip_effect_engine: frame ticks in, pixel beats out.
// Builds its own frame/pixel predictor and compares every output beat against it.
// Depends on lse_pkg (register indexes, mode codes, port widths) and the RTL.

module tb_top;

  localparam int              NUM_LEDS   = 16;
  localparam int              SETTLE     = 8;          // cycles to let the pipeline go quiet
  localparam longint unsigned PI_FIX     = 843314857;  // pi in Q28
  localparam int unsigned     SECTOR     = 43;         // hue span of one HSV region
  localparam logic [1:0]      MODE_CODE3 = 2'd3;       // undefined code, acts as hold
  localparam logic [lse_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;  // index with no register

  // one expected or observed pixel beat
  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [0] phone_up
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;  // [5:0] idx, [13:6] r, [21:14] g, [29:22] b
  logic                           m_axis_tlast;

  // mirror of the config registers
  logic [1:0] src_mode = lse_pkg::MODE_FIXED;
  logic       anim_en  = 1'b0;
  logic [7:0] base_r = 8'd255, base_g = 8'd255, base_b = 8'd255;
  logic [7:0] lvl_min = 8'd16, lvl_max = 8'd255;

  // mirror of the frame state
  logic [7:0] hue_acc = 8'd0;
  logic [7:0] frame_r = 8'd255, frame_g = 8'd255, frame_b = 8'd255;
  logic [7:0] level = 8'd0;
  int unsigned wave_pos = 0;

  pixel_t pixel_q[$];       // pixels still owed by the DUT, oldest first

  // bookkeeping
  int  err_cnt = 0;
  int  ticks_sent = 0;
  int  beats_checked = 0;
  int  wave_ticks = 0;
  bit  gap_en = 1'b1;       // sender may insert idle bursts
  bit  stall_en = 1'b1;     // receiver may drop tready in bursts
  int  stall_left = 0;
  pixel_t seen_px, want_px;

  led_strip_effect_engine #(.NUM_LEDS(NUM_LEDS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #(20 * 1000000);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Half-sine weight in Q1.8 for wave slot t. Sine from a Q28 Taylor series,
  // only the first half of the strip is lit.
  function automatic int unsigned wave_weight(input int unsigned t);
    longint unsigned u, x, x2, term, acc, w;
    int unsigned k;
    if (t == 0 || 2 * t >= NUM_LEDS) return 0;
    u = 2 * t;
    if (NUM_LEDS - u < u) u = NUM_LEDS - u;
    x = (PI_FIX * u) / NUM_LEDS;
    x2 = (x * x) >> 28;
    term = x;
    acc = x;
    for (k = 1; k <= 5; k++) begin
      term = (term * x2) / (longint'(2 * k) * longint'(2 * k + 1));
      if (k[0]) acc = (acc >= term) ? acc - term : 0;
      else      acc = acc + term;
    end
    w = (acc + (64'd1 << 19)) >> 20;
    return (w > 256) ? 256 : 32'(w);
  endfunction

  // Advance the frame state for one accepted tick and queue its pixels.
  task automatic predict_frame(input bit up);
    int unsigned region, rem, q, t, v, w, target, i;
    bit wave;
    pixel_t px;
    wave = up && anim_en;

    // settle the frame color
    if (src_mode == lse_pkg::MODE_RAINBOW) begin
      hue_acc = hue_acc + 8'd1;
      v = lvl_max;
      region = hue_acc / SECTOR;
      rem = (hue_acc - region * SECTOR) * 6;
      q = (v * (255 - ((255 * rem) >> 8))) >> 8;
      t = (v * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
      case (region)
        0:       begin frame_r = 8'(v); frame_g = 8'(t); frame_b = 8'd0;  end
        1:       begin frame_r = 8'(q); frame_g = 8'(v); frame_b = 8'd0;  end
        2:       begin frame_r = 8'd0;  frame_g = 8'(v); frame_b = 8'(t); end
        3:       begin frame_r = 8'd0;  frame_g = 8'(q); frame_b = 8'(v); end
        4:       begin frame_r = 8'(t); frame_g = 8'd0;  frame_b = 8'(v); end
        default: begin frame_r = 8'(v); frame_g = 8'd0;  frame_b = 8'(q); end
      endcase
    end else if (src_mode == lse_pkg::MODE_FIXED) begin
      frame_r = base_r;
      frame_g = base_g;
      frame_b = base_b;
    end

    // brightness ramps one step per tick, frozen while the wave runs
    if (!wave) begin
      target = up ? lvl_min : lvl_max;
      if (level < target)      level = level + 8'd1;
      else if (level > target) level = level - 8'd1;
    end

    for (i = 0; i < NUM_LEDS; i++) begin
      px.idx  = i[5:0];
      px.last = (i == NUM_LEDS - 1);
      if (wave) begin
        w = wave_weight((i + wave_pos) % NUM_LEDS);
        px.r = 8'((frame_r * w) >> 8);
        px.g = 8'((frame_g * w) >> 8);
        px.b = 8'((frame_b * w) >> 8);
      end else begin
        px.r = 8'((frame_r * level) / 255);
        px.g = 8'((frame_g * level) / 255);
        px.b = 8'((frame_b * level) / 255);
      end
      pixel_q.push_back(px);
    end

    if (wave) begin
      wave_pos = (wave_pos + 1 == NUM_LEDS) ? 0 : wave_pos + 1;
      wave_ticks++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One register write; a dead cycle after it keeps cfg_we edges apart.
  task automatic set_reg(input logic [lse_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lse_pkg::REG_RAINBOW_MODE:   src_mode = val[1:0];
      lse_pkg::REG_ANIMATE_ENABLE: anim_en  = val[0];
      lse_pkg::REG_BASE_RED:       base_r   = val;
      lse_pkg::REG_BASE_GREEN:     base_g   = val;
      lse_pkg::REG_BASE_BLUE:      base_b   = val;
      lse_pkg::REG_BRIGHT_MIN:     lvl_min  = val;
      lse_pkg::REG_BRIGHT_MAX:     lvl_max  = val;
      default:                     ;        // no register: write is dropped
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one tick beat; return once it is taken. tvalid stays up, so
  // back-to-back ticks keep it asserted without a drop in between.
  task automatic send_tick(input bit up);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, up};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_frame(up);
    ticks_sent++;
  endtask

  // Hold off until every owed pixel is back and the block is quiet.
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random tready bursts and the beat checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= int'($urandom_range(0, 13));  // start a random-length low burst
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_px = '{idx: m_axis_tdata[5:0], r: m_axis_tdata[13:6], g: m_axis_tdata[21:14],
                  b: m_axis_tdata[29:22], last: m_axis_tlast};
      if (pixel_q.size() == 0) begin
        if (err_cnt < 10)
          $display("[%0t] unexpected pixel beat: idx %0d rgb %0d,%0d,%0d last %0b",
                   $realtime, seen_px.idx, seen_px.r, seen_px.g, seen_px.b, seen_px.last);
        err_cnt++;
      end else begin
        want_px = pixel_q.pop_front();
        beats_checked++;
        if (seen_px != want_px) begin
          if (err_cnt < 10) begin
            $display("[%0t] pixel mismatch: exp idx %0d rgb %0d,%0d,%0d last %0b",
                     $realtime, want_px.idx, want_px.r, want_px.g, want_px.b, want_px.last);
            $display("        got idx %0d rgb %0d,%0d,%0d last %0b",
                     seen_px.idx, seen_px.r, seen_px.g, seen_px.b, seen_px.last);
          end
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on settings: fixed white, brightness climbs from zero, then heads
  // toward bright_min once the handset lifts.
  task automatic test_power_on();
    repeat (3) send_tick(1'b0);
    repeat (2) send_tick(1'b1);
    drain_wait();
  endtask

  // Fixed color at channel extremes, brightness target pulled to zero.
  task automatic test_fixed_extremes();
    set_reg(lse_pkg::REG_BASE_RED,   8'd255);
    set_reg(lse_pkg::REG_BASE_GREEN, 8'd0);
    set_reg(lse_pkg::REG_BASE_BLUE,  8'd170);
    repeat (2) send_tick(1'b0);
    drain_wait();
    set_reg(lse_pkg::REG_BASE_RED,   8'd0);
    set_reg(lse_pkg::REG_BASE_GREEN, 8'd255);
    set_reg(lse_pkg::REG_BASE_BLUE,  8'd85);
    set_reg(lse_pkg::REG_BRIGHT_MAX, 8'd0);
    set_reg(lse_pkg::REG_BRIGHT_MIN, 8'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_wait();
  endtask

  // Hold keeps the last frame color even when the base color changes; mode
  // code 3 behaves the same. Out-of-range bits of the mode write are masked.
  task automatic test_hold_modes();
    set_reg(lse_pkg::REG_BRIGHT_MAX, 8'd200);
    set_reg(lse_pkg::REG_RAINBOW_MODE, 8'hFC | 8'(lse_pkg::MODE_RAINBOW));
    send_tick(1'b0);
    drain_wait();
    set_reg(lse_pkg::REG_RAINBOW_MODE, 8'(lse_pkg::MODE_HOLD));
    set_reg(lse_pkg::REG_BASE_RED, 8'd17);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_wait();
    set_reg(lse_pkg::REG_RAINBOW_MODE, 8'(MODE_CODE3));
    send_tick(1'b0);
    drain_wait();
    // a write to an unused index must not disturb anything
    set_reg(REG_NONE, 8'hFF);
    set_reg(lse_pkg::REG_RAINBOW_MODE, 8'(lse_pkg::MODE_FIXED));
    send_tick(1'b0);
    drain_wait();
  endtask

  // Rotating wave: more than one full turn so the offset wraps, then a
  // phone-down tick proves brightness stayed put while animating.
  task automatic test_wave();
    set_reg(lse_pkg::REG_BASE_RED,   8'd255);
    set_reg(lse_pkg::REG_BASE_GREEN, 8'd128);
    set_reg(lse_pkg::REG_BASE_BLUE,  8'd1);
    set_reg(lse_pkg::REG_BRIGHT_MAX, 8'd255);
    set_reg(lse_pkg::REG_ANIMATE_ENABLE, 8'hFF);
    repeat (NUM_LEDS + 2) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_wait();
    set_reg(lse_pkg::REG_ANIMATE_ENABLE, 8'h00);
  endtask

  // Rainbow ramp within the first HSV region with the phone down, so
  // brightness keeps climbing as the hue moves.
  task automatic test_hue_sweep();
    set_reg(lse_pkg::REG_RAINBOW_MODE, 8'(lse_pkg::MODE_RAINBOW));
    set_reg(lse_pkg::REG_BRIGHT_MAX, 8'd255);
    repeat (30) send_tick(1'b0);
    drain_wait();
  endtask

  // Random register settings between phases, random ticks within them.
  // Wave phases lean on phone-up so the rotation gets exercised.
  task automatic test_random(input int n_ticks);
    int sent, n, i;
    bit up;
    sent = 0;
    while (sent < n_ticks) begin
      drain_wait();
      if ($urandom_range(0, 1))
        set_reg(lse_pkg::REG_RAINBOW_MODE,
                (8'($urandom) & 8'hFC) | 8'($urandom_range(0, 3)));
      if ($urandom_range(0, 1)) set_reg(lse_pkg::REG_ANIMATE_ENABLE, 8'($urandom));
      if ($urandom_range(0, 1))
        set_reg(lse_pkg::REG_BASE_RED, $urandom_range(0, 3) ? 8'($urandom) : 8'hFF);
      if ($urandom_range(0, 1))
        set_reg(lse_pkg::REG_BASE_GREEN, $urandom_range(0, 3) ? 8'($urandom) : 8'h00);
      if ($urandom_range(0, 1)) set_reg(lse_pkg::REG_BASE_BLUE, 8'($urandom));
      if ($urandom_range(0, 1))
        set_reg(lse_pkg::REG_BRIGHT_MIN, $urandom_range(0, 2) ? 8'($urandom) : 8'h00);
      if ($urandom_range(0, 1))
        set_reg(lse_pkg::REG_BRIGHT_MAX, $urandom_range(0, 2) ? 8'($urandom) : 8'hFF);
      if ($urandom_range(0, 7) == 0) set_reg(REG_NONE, 8'($urandom));
      // final stretch runs with both sides streaming flat out
      if (n_ticks - sent <= 20) begin
        gap_en   = 1'b0;
        stall_en = 1'b0;
      end
      n = int'($urandom_range(4, 12));
      for (i = 0; i < n; i++) begin
        up = anim_en ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) != 0);
        send_tick(up);
      end
      sent += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_on();
    test_fixed_extremes();
    test_hold_modes();
    test_wave();
    test_hue_sweep();
    test_random(40);

    drain_wait();
    $display("Run covered %0d frame ticks (%0d with the wave), %0d pixel beats compared.",
             ticks_sent, wave_ticks, beats_checked);
    $display("Modes fixed/rainbow/hold, hue ramp, register extremes, %0d mismatches.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
